FILE: hw/rtl/consistent_hash_ring_table_top_assert.svh
// Assertion macros used by the checker file.
`ifndef CONSISTENT_HASH_RING_TABLE_TOP_ASSERT_SVH
`define CONSISTENT_HASH_RING_TABLE_TOP_ASSERT_SVH

// Check that cond_a implies cond_b in the same cycle.
`define CHRT_ASSERT_IMPL(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond_a) |-> (cond_b)) else $error(msg);

// Check that cond_a implies cond_b in the next cycle.
`define CHRT_ASSERT_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond_a) |=> (cond_b)) else $error(msg);

`endif

FILE: hw/rtl/chrt_pkg.sv
package chrt_pkg;

  localparam int unsigned HASH_W  = 32;
  localparam int unsigned ID_W    = 20;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned ENT_W   = HASH_W + ID_W;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_LOOK_WAIT,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_e;

endpackage

FILE: hw/rtl/chrt_ram.sv
module chrt_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/consistent_hash_ring_table_top.sv
// Sorted hash ring: up to RING_DEPTH entries (32-bit hash, 20-bit server id) kept in ascending
// hash order in one simple dual-port RAM (one write, one registered read per cycle). Every item
// gives exactly one result. A lookup runs a binary search over the n stored entries, with one
// RAM read and one compare per step, then reads the successor entry. An insert runs the same
// search, moves the entries above the slot up one at a time and writes the new entry; a remove
// moves the entries above the hole down one at a time. Errors (full, empty, bad position,
// unknown action) answer without a search. One item is worked at a time; the next item is
// taken while the previous result still waits in the output register. Unused result fields
// read as zero.
module consistent_hash_ring_table_top
  import chrt_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] ring_key, [51:32] node_id, [59:52] position, [63:60] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] index, [27:8] owner_id, [31:28] zero
  output logic [31:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic               out_valid_q, out_valid_d;

  logic [1:0]         act_q, act_d;
  logic [HASH_W-1:0]  key_q, key_d;
  logic [ID_W-1:0]    sid_q, sid_d;
  logic [CNT_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]   hi_q, hi_d;
  logic [CNT_W-1:0]   mid_q, mid_d;
  logic [CNT_W-1:0]   cur_q, cur_d;
  logic [IDX_W-1:0]   pdst_q, pdst_d;
  logic [INDEX_W-1:0] res_idx_q, res_idx_d;
  logic [ID_W-1:0]    res_own_q, res_own_d;
  status_e            res_st_q, res_st_d;
  logic [INDEX_W-1:0] out_idx_q, out_idx_d;
  logic [ID_W-1:0]    out_own_q, out_own_d;
  status_e            out_st_q, out_st_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;

  logic               in_fire;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   succ;
  logic [CNT_W-1:0]   src;
  logic               more;
  logic               is_insert;

  chrt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(RING_DEPTH)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign is_insert     = (act_q == ACT_INSERT);

  assign mid  = lo_q + ((hi_q - lo_q) >> 1);
  // wrap to the first entry when the key lies above the last one
  assign succ = (lo_q >= cnt_q) ? '0 : lo_q;
  // insert moves entries up from the top, remove moves them down from the hole
  assign more = is_insert ? (cur_q > lo_q) : ((cur_q + 1'b1) < cnt_q);
  assign src  = is_insert ? (cur_q - 1'b1) : (cur_q + 1'b1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    act_d       = act_q;
    key_d       = key_q;
    sid_d       = sid_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    cur_d       = cur_q;
    pdst_d      = pdst_q;
    res_idx_d   = res_idx_q;
    res_own_d   = res_own_q;
    res_st_d    = res_st_q;
    out_idx_d   = out_idx_q;
    out_own_d   = out_own_q;
    out_st_d    = out_st_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_d     = s_axis_tuser;
          key_d     = s_axis_tdata[HASH_W-1:0];
          sid_d     = s_axis_tdata[HASH_W+ID_W-1:HASH_W];
          res_idx_d = '0;
          res_own_d = '0;
          res_st_d  = STAT_OK;
          lo_d      = '0;
          hi_d      = cnt_q;
          pend_d    = 1'b0;
          case (action_e'(s_axis_tuser))
            ACT_LOOKUP: begin
              if (cnt_q == '0) begin
                res_st_d = STAT_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            ACT_INSERT: begin
              if (cnt_q == CNT_W'(RING_DEPTH)) begin
                res_st_d = STAT_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            ACT_REMOVE: begin
              if (CMP_W'(s_axis_tdata[HASH_W+ID_W+POS_W-1:HASH_W+ID_W]) >= CMP_W'(cnt_q)) begin
                res_st_d = STAT_BADPOS;
                state_d  = S_DONE;
              end else begin
                cur_d   = CNT_W'(s_axis_tdata[HASH_W+ID_W+POS_W-1:HASH_W+ID_W]);
                state_d = S_SHIFT;
              end
            end
            default: begin
              res_st_d = STAT_BADPOS;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        if (lo_q < hi_q) begin
          ram_raddr = IDX_W'(mid);
          mid_d     = mid;
          state_d   = S_SRCH_CMP;
        end else if (is_insert) begin
          res_idx_d = INDEX_W'(lo_q);
          cur_d     = cnt_q;
          pend_d    = 1'b0;
          state_d   = S_SHIFT;
        end else begin
          ram_raddr = IDX_W'(succ);
          res_idx_d = INDEX_W'(succ);
          state_d   = S_LOOK_WAIT;
        end
      end

      S_SRCH_CMP: begin
        if (ram_rdata[ENT_W-1:ID_W] < key_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SRCH_RD;
      end

      S_LOOK_WAIT: begin
        res_own_d = ram_rdata[ID_W-1:0];
        state_d   = S_DONE;
      end

      S_SHIFT: begin
        // write back the entry read in the previous cycle
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pdst_q;
          ram_wdata = ram_rdata;
        end
        if (more) begin
          ram_raddr = IDX_W'(src);
          pend_d    = 1'b1;
          pdst_d    = IDX_W'(cur_q);
          cur_d     = src;
        end else begin
          pend_d = 1'b0;
          if (is_insert) begin
            state_d = S_PLACE;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            state_d = S_DONE;
          end
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(lo_q);
        ram_wdata = {key_q, sid_q};
        cnt_d     = cnt_q + 1'b1;
        state_d   = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_own_d   = res_own_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    key_q     <= key_d;
    sid_q     <= sid_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    cur_q     <= cur_d;
    pdst_q    <= pdst_d;
    res_idx_q <= res_idx_d;
    res_own_q <= res_own_d;
    res_st_q  <= res_st_d;
    out_idx_q <= out_idx_d;
    out_own_q <= out_own_d;
    out_st_q  <= out_st_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_own_q, out_idx_q};
  assign m_axis_tuser  = out_st_q;

endmodule

FILE: hw/rtl/chrt_checker.sv
`include "consistent_hash_ring_table_top_assert.svh"

module chrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] open_q, open_d;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  // count items taken whose result has not left yet
  always_comb begin
    open_d = open_q;
    if (in_fire && !out_fire) begin
      open_d = open_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      open_d = open_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  `CHRT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result changed while stalled")

  `CHRT_ASSERT_IMPL(a_no_spurious, m_axis_tvalid, open_q != 2'd0,
    "result without an accepted item")

  `CHRT_ASSERT_IMPL(a_bounded, 1'b1, open_q != 2'd3,
    "more than two items in flight")

  `CHRT_ASSERT_IMPL(a_busy_blocks, open_q == 2'd2, !s_axis_tready,
    "item accepted while block is full")

endmodule

bind consistent_hash_ring_table_top chrt_checker u_chrt_checker (.*);

FILE: test/consistent_hash_ring_table_top_test.sv
`timescale 1ns / 100ps

module consistent_hash_ring_table_top_test;
  import chrt_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int RANDOM_ITEMS = 1530;
  localparam int HOLD_AT_ITEM = 1100;
  localparam int HOLD_CYCLES = 3 * RING_DEPTH;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int MAX_REPORTS = 10;
  // action code with no meaning; the block answers it as a bad position
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] ring_key;
    logic [19:0] node_id;
    logic [7:0]  position;
  } ring_op_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [19:0] owner_id;
    status_e     status;
  } ring_reply_t;

  typedef struct {
    ring_op_t    op;
    bit          typed;
    ring_reply_t reply;
  } ring_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // ring image kept in step with the accepted items
  logic [31:0] ring_hash [RING_DEPTH];
  logic [19:0] ring_owner [RING_DEPTH];
  int          ring_fill = 0;

  ring_reply_t pending_results [$];
  ring_row_t   directed_rows [$];
  int          items_sent = 0;
  int          error_count = 0;
  int          src_idle_pct = 23;
  int          rcv_idle_pct = 53;
  int          cycle_count = 0;
  logic        rx_hold = 1'b0;

  consistent_hash_ring_table_top #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int first_not_below(logic [31:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = ring_fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (ring_hash[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic ring_reply_t apply_ring_action(ring_op_t op);
    ring_reply_t r;
    int slot;
    r.index = '0;
    r.owner_id = '0;
    r.status = STAT_OK;
    case (op.action)
      ACT_LOOKUP: begin
        if (ring_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          slot = first_not_below(op.ring_key);
          // wrap past the last entry
          if (slot >= ring_fill) slot = 0;
          r.index = slot[7:0];
          r.owner_id = ring_owner[slot];
        end
      end
      ACT_INSERT: begin
        if (ring_fill >= RING_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          slot = first_not_below(op.ring_key);
          for (int i = ring_fill; i > slot; i--) begin
            ring_hash[i] = ring_hash[i - 1];
            ring_owner[i] = ring_owner[i - 1];
          end
          ring_hash[slot] = op.ring_key;
          ring_owner[slot] = op.node_id;
          ring_fill++;
          r.index = slot[7:0];
        end
      end
      ACT_REMOVE: begin
        if (int'(op.position) >= ring_fill) begin
          r.status = STAT_BADPOS;
        end else begin
          for (int i = int'(op.position); i + 1 < ring_fill; i++) begin
            ring_hash[i] = ring_hash[i + 1];
            ring_owner[i] = ring_owner[i + 1];
          end
          ring_fill--;
        end
      end
      default: r.status = STAT_BADPOS;
    endcase
    return r;
  endfunction

  task automatic add_row(input logic [1:0] action, input logic [31:0] key,
                         input logic [19:0] sid, input logic [7:0] pos, input bit typed,
                         input logic [7:0] idx, input logic [19:0] owner, input status_e st);
    ring_row_t row;
    row.op.action = action;
    row.op.ring_key = key;
    row.op.node_id = sid;
    row.op.position = pos;
    row.typed = typed;
    row.reply.index = idx;
    row.reply.owner_id = owner;
    row.reply.status = st;
    directed_rows.push_back(row);
  endtask

  task automatic drive_item(input ring_op_t op, input ring_reply_t want);
    if (items_sent < 517) begin
      src_idle_pct = 23;
      rcv_idle_pct = 53;
    end else if (items_sent < 1034) begin
      src_idle_pct = 53;
      rcv_idle_pct = 23;
    end else begin
      src_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, op.position, op.node_id, op.ring_key};
    s_axis_tuser <= op.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(want);
    items_sent++;
  endtask

  initial begin
    ring_op_t op;
    ring_reply_t want;
    bit growing;
    int pick;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(ACT_LOOKUP, 32'h0000_1234, 20'h0, 8'h0, 1, 8'd0, 20'h0, STAT_EMPTY);
    add_row(ACT_REMOVE, 32'h0, 20'h0, 8'd0, 1, 8'd0, 20'h0, STAT_BADPOS);
    add_row(ACT_UNUSED, 32'h0, 20'h0, 8'd0, 1, 8'd0, 20'h0, STAT_BADPOS);
    add_row(ACT_INSERT, 32'h8000_0000, 20'hFFFFF, 8'd0, 1, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_INSERT, 32'h0000_0000, 20'h00000, 8'd0, 1, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_INSERT, 32'hFFFF_FFFF, 20'h12345, 8'hFF, 1, 8'd2, 20'h0, STAT_OK);
    // equal hash goes in front of the stored one
    add_row(ACT_INSERT, 32'h8000_0000, 20'hABCDE, 8'd0, 0, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_LOOKUP, 32'h0000_0000, 20'hFFFFF, 8'hFF, 1, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_LOOKUP, 32'h8000_0000, 20'h0, 8'd0, 0, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_LOOKUP, 32'h8000_0001, 20'h0, 8'd0, 0, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 20'h0, 8'd0, 0, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_REMOVE, 32'h0, 20'h0, 8'd4, 1, 8'd0, 20'h0, STAT_BADPOS);
    add_row(ACT_REMOVE, 32'hFFFF_FFFF, 20'hFFFFF, 8'd255, 1, 8'd0, 20'h0, STAT_BADPOS);
    add_row(ACT_UNUSED, 32'hFFFF_FFFF, 20'hFFFFF, 8'hFF, 1, 8'd0, 20'h0, STAT_BADPOS);
    add_row(ACT_REMOVE, 32'h0, 20'h0, 8'd3, 1, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_LOOKUP, 32'h8000_0001, 20'h0, 8'd0, 0, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_REMOVE, 32'h0, 20'h0, 8'd0, 1, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_LOOKUP, 32'h0000_0000, 20'h0, 8'd0, 0, 8'd0, 20'h0, STAT_OK);
    add_row(ACT_LOOKUP, 32'h9000_0000, 20'h0, 8'd0, 0, 8'd0, 20'h0, STAT_OK);

    foreach (directed_rows[i]) begin
      want = apply_ring_action(directed_rows[i].op);
      if (directed_rows[i].typed) want = directed_rows[i].reply;
      drive_item(directed_rows[i].op, want);
    end

    // grow the ring to full, linger there, drain it to empty, repeat
    growing = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (growing && ring_fill == RING_DEPTH && $urandom_range(19) == 0) growing = 1'b0;
      if (!growing && ring_fill == 0 && $urandom_range(4) == 0) growing = 1'b1;
      op.ring_key = $urandom();
      op.node_id = 20'($urandom_range(20'hFFFFF));
      op.position = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 60) op.action = growing ? ACT_INSERT : ACT_REMOVE;
      else if (pick < 80) op.action = ACT_LOOKUP;
      else if (pick < 97) op.action = growing ? ACT_REMOVE : ACT_INSERT;
      else op.action = ACT_UNUSED;
      if (op.action == ACT_REMOVE && ring_fill > 0 && $urandom_range(9) != 0) begin
        op.position = 8'($urandom_range(ring_fill - 1));
      end
      // aim keys at stored hashes to hit equal and neighboring entries
      if (op.action != ACT_REMOVE && ring_fill > 0 && $urandom_range(3) == 0) begin
        op.ring_key = ring_hash[$urandom_range(ring_fill - 1)] + $urandom_range(1);
      end else if ($urandom_range(19) == 0) begin
        op.ring_key = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
      want = apply_ring_action(op);
      drive_item(op, want);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (RING_DEPTH + 32) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("consistent_hash_ring_table_top test passed");
    end else begin
      $display("consistent_hash_ring_table_top test failed");
    end
    $finish;
  end

  initial begin
    ring_reply_t got;
    ring_reply_t want;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.index = m_axis_tdata[7:0];
        got.owner_id = m_axis_tdata[27:8];
        got.status = status_e'(m_axis_tuser);
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result: index %0d owner %h status %0d",
                     got.index, got.owner_id, got.status);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.index !== want.index || got.owner_id !== want.owner_id ||
              got.status !== want.status) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display({"mismatch: expected index %0d owner %h status %0d, ",
                        "got index %0d owner %h status %0d"},
                       want.index, want.owner_id, want.status,
                       got.index, got.owner_id, got.status);
            end
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // hold the output off long enough for the block to back up and stall its input
  initial begin
    while (items_sent < HOLD_AT_ITEM) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("consistent_hash_ring_table_top test failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/chrt_pkg.sv
hw/rtl/chrt_ram.sv
hw/rtl/consistent_hash_ring_table_top.sv
hw/rtl/chrt_checker.sv
test/consistent_hash_ring_table_top_test.sv
